/* rtl/trss_pkg.sv */
// Shared types and constants for the three-way range scan sequencer.
package trss_pkg;

	localparam int unsigned DIST_W = 16;
	localparam int unsigned COUNT_W = 16;

	localparam logic [COUNT_W-1:0] SETTLE_TICKS_RST = 16'd300;
	localparam logic [DIST_W-1:0] MAX_DISTANCE_RST = 16'd6400;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

	// configuration register indexes
	typedef enum logic {
		CFG_SETTLE_TICKS = 1'b0,
		CFG_MAX_DISTANCE = 1'b1
	} cfg_index_t;

	// scanner aim codes
	localparam logic [1:0] AIM_LEFT = 2'd0;
	localparam logic [1:0] AIM_FRONT = 2'd1;
	localparam logic [1:0] AIM_RIGHT = 2'd2;

	// reported phase codes
	localparam logic [2:0] PHASE_IDLE = 3'd0;
	localparam logic [2:0] PHASE_LEFT = 3'd1;
	localparam logic [2:0] PHASE_FRONT = 3'd2;
	localparam logic [2:0] PHASE_RIGHT = 3'd3;
	localparam logic [2:0] PHASE_DONE = 3'd4;

	// best direction codes
	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_FRONT = 2'd1;
	localparam logic [1:0] DIR_LEFT = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_START = 1'b1
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LEFT = 5'b00010,
		ST_FRONT = 5'b00100,
		ST_RIGHT = 5'b01000,
		ST_DONE = 5'b10000
	} phase_t;

	typedef struct packed {
		logic req_type;
		logic [DIST_W-1:0] distance_reading;
		logic reading_failed;
	} trss_in_t;

	typedef struct packed {
		logic [1:0] servo_position;
		logic [2:0] scan_phase;
		logic scanning;
		logic scan_complete;
		logic sample_taken;
		logic [DIST_W-1:0] left_distance;
		logic [DIST_W-1:0] front_distance;
		logic [DIST_W-1:0] right_distance;
		logic [1:0] best_direction;
	} trss_out_t;

	// classified command passed from front to back
	typedef struct packed {
		op_t op;
		logic [DIST_W-1:0] value;
	} trss_cmd_t;

endpackage

/* rtl/three_way_range_scan_sequencer.sv */
// Top level of the three-way range scan sequencer.
// Steps a range sensor through left, front and right: a start transfer begins a scan, each
// tick transfer advances the settle counter and, once settle_ticks is reached, stores the
// reading for the current aim and turns to the next one. Every input transfer yields one
// result transfer. The block sustains one transfer per cycle while the output is not stalled;
// a result passes through the front register, a command queue of QUEUE_DEPTH entries and the
// result register. The back end updates its whole state on each accepted command, which sets
// that rate. Configuration registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while no transfer is in flight, as the block itself does not enforce this.
module three_way_range_scan_sequencer
	import trss_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  trss_in_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output trss_out_t out_data,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [15:0] cfg_data
);

	logic [COUNT_W-1:0] settle_ticks_q;
	logic [DIST_W-1:0] max_distance_q;
	logic front_valid, front_ready;
	trss_cmd_t front_cmd;
	logic back_valid, back_ready;
	trss_cmd_t back_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_ticks_q <= SETTLE_TICKS_RST;
			max_distance_q <= MAX_DISTANCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_SETTLE_TICKS: settle_ticks_q <= cfg_data;
				CFG_MAX_DISTANCE: max_distance_q <= cfg_data;
				default: ;
			endcase
		end
	end

	trss_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.max_distance (max_distance_q),
		.cmd_valid    (front_valid),
		.cmd_ready    (front_ready),
		.cmd          (front_cmd)
	);

	trss_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_cmd    (back_cmd)
	);

	trss_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (back_valid),
		.cmd_ready    (back_ready),
		.cmd          (back_cmd),
		.settle_ticks (settle_ticks_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data)
	);

endmodule

/* rtl/trss_front.sv */
// Front end: accepts input transfers, classifies them and resolves failed readings.
module trss_front
	import trss_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  trss_in_t in_data,
	input  logic [DIST_W-1:0] max_distance,
	output logic cmd_valid,
	input  logic cmd_ready,
	output trss_cmd_t cmd
);

	logic cmd_valid_s1;
	trss_cmd_t cmd_s1;
	trss_cmd_t cmd_next;

	assign in_ready = !cmd_valid_s1 || cmd_ready;

	always_comb begin
		cmd_next.op = in_data.req_type ? OP_START : OP_TICK;
		cmd_next.value = in_data.reading_failed ? max_distance : in_data.distance_reading;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			cmd_valid_s1 <= 1'b1;
		end else if (cmd_ready) begin
			cmd_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd_next;
		end
	end

	assign cmd_valid = cmd_valid_s1;
	assign cmd = cmd_s1;

endmodule

/* rtl/trss_queue.sv */
// Short command queue between the front end and the sequencer back end.
module trss_queue
	import trss_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  trss_cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output trss_cmd_t pop_cmd
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	trss_cmd_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;
	assign pop_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

/* rtl/trss_back.sv */
// Back end: scan state machine, settle counter, stored distances and result register.
module trss_back
	import trss_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  trss_cmd_t cmd,
	input  logic [COUNT_W-1:0] settle_ticks,
	output logic out_valid,
	input  logic out_ready,
	output trss_out_t out_data
);

	phase_t phase_q, phase_d;
	logic [COUNT_W-1:0] count_q, count_d, count_inc;
	logic [1:0] aim_q, aim_d;
	logic [DIST_W-1:0] left_q, left_d;
	logic [DIST_W-1:0] front_q, front_d;
	logic [DIST_W-1:0] right_q, right_d;
	logic in_scan;
	logic sampled;
	logic pop;
	logic out_valid_q;
	trss_out_t out_q, out_next;

	assign cmd_ready = !out_valid_q || out_ready;
	assign pop = cmd_valid && cmd_ready;
	assign in_scan = (phase_q == ST_LEFT) || (phase_q == ST_FRONT) || (phase_q == ST_RIGHT);
	assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		aim_d = aim_q;
		left_d = left_q;
		front_d = front_q;
		right_d = right_q;
		sampled = 1'b0;
		if (cmd.op == OP_START) begin
			if (!in_scan) begin
				left_d = '0;
				front_d = '0;
				right_d = '0;
				aim_d = AIM_LEFT;
				phase_d = ST_LEFT;
				count_d = '0;
			end
		end else if (in_scan) begin
			count_d = count_inc;
			if (count_inc >= settle_ticks) begin
				sampled = 1'b1;
				count_d = '0;
				priority case (phase_q)
					ST_LEFT: begin
						left_d = cmd.value;
						aim_d = AIM_FRONT;
						phase_d = ST_FRONT;
					end
					ST_FRONT: begin
						front_d = cmd.value;
						aim_d = AIM_RIGHT;
						phase_d = ST_RIGHT;
					end
					default: begin
						right_d = cmd.value;
						aim_d = AIM_FRONT;
						phase_d = ST_DONE;
					end
				endcase
			end
		end
	end

	always_comb begin
		out_next.servo_position = aim_d;
		out_next.sample_taken = sampled;
		out_next.left_distance = left_d;
		out_next.front_distance = front_d;
		out_next.right_distance = right_d;
		out_next.scanning = (phase_d == ST_LEFT) || (phase_d == ST_FRONT)
			|| (phase_d == ST_RIGHT);
		out_next.scan_complete = (phase_d == ST_DONE);
		unique case (phase_d)
			ST_IDLE:  out_next.scan_phase = PHASE_IDLE;
			ST_LEFT:  out_next.scan_phase = PHASE_LEFT;
			ST_FRONT: out_next.scan_phase = PHASE_FRONT;
			ST_RIGHT: out_next.scan_phase = PHASE_RIGHT;
			ST_DONE:  out_next.scan_phase = PHASE_DONE;
			default:  out_next.scan_phase = PHASE_IDLE;
		endcase
		// preference on ties: front, then left, then right
		if (phase_d != ST_DONE) begin
			out_next.best_direction = DIR_NONE;
		end else if (front_d >= left_d && front_d >= right_d) begin
			out_next.best_direction = DIR_FRONT;
		end else if (left_d >= right_d) begin
			out_next.best_direction = DIR_LEFT;
		end else begin
			out_next.best_direction = DIR_RIGHT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ST_IDLE;
			count_q <= '0;
			aim_q <= AIM_FRONT;
			left_q <= '0;
			front_q <= '0;
			right_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_d;
				count_q <= count_d;
				aim_q <= aim_d;
				left_q <= left_d;
				front_q <= front_d;
				right_q <= right_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= out_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

/* rtl/trss_checker.sv */
// Port-level checks for the three-way range scan sequencer, with bind.
module trss_checker
	import trss_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input trss_out_t out_data
);

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.scanning && out_data.scan_complete))
		else $error("scanning and complete both set");

	a_best: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.best_direction != DIR_NONE) |-> out_data.scan_complete)
		else $error("best direction before scan complete");

	a_sample: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.sample_taken |->
			(out_data.scan_phase == PHASE_FRONT) || (out_data.scan_phase == PHASE_RIGHT)
			|| (out_data.scan_phase == PHASE_DONE))
		else $error("sample taken in impossible phase");

	a_aim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.scan_phase == PHASE_LEFT) |->
			out_data.servo_position == AIM_LEFT)
		else $error("aim does not match left phase");

endmodule

bind three_way_range_scan_sequencer trss_checker u_trss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

/* dv/scan_result_checker.sv */
// Checker for the range scan sequencer: predicts each result and compares it.
module scan_result_checker
	import trss_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  trss_in_t in_data,
	input  logic out_valid,
	input  logic out_ready,
	input  trss_out_t out_data,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [15:0] cfg_data,
	output int fail_count,
	output int pending,
	output int results_checked,
	output int readings_stored,
	output int scans_completed
);

	logic [COUNT_W-1:0] settle_limit;
	logic [DIST_W-1:0] fail_distance;

	logic [2:0] scan_state;
	logic [COUNT_W-1:0] settle_cnt;
	logic [1:0] aim;
	logic [DIST_W-1:0] left_dist;
	logic [DIST_W-1:0] front_dist;
	logic [DIST_W-1:0] right_dist;

	trss_out_t expected_results[$];

	function automatic logic scan_busy();
		return scan_state == PHASE_LEFT || scan_state == PHASE_FRONT ||
			scan_state == PHASE_RIGHT;
	endfunction

	// applies one input transfer to the predicted state, returns the resulting output
	function automatic trss_out_t advance_scan(trss_in_t item);
		trss_out_t r;
		logic [DIST_W-1:0] value;
		logic took;
		took = 1'b0;
		if (item.req_type == OP_START) begin
			if (!scan_busy()) begin
				left_dist = '0;
				front_dist = '0;
				right_dist = '0;
				aim = AIM_LEFT;
				scan_state = PHASE_LEFT;
				settle_cnt = '0;
			end
		end else if (scan_busy()) begin
			value = item.reading_failed ? fail_distance : item.distance_reading;
			if (settle_cnt != COUNT_MAX)
				settle_cnt = settle_cnt + 1'b1;
			if (settle_cnt >= settle_limit) begin
				took = 1'b1;
				case (scan_state)
					PHASE_LEFT: begin
						left_dist = value;
						aim = AIM_FRONT;
						scan_state = PHASE_FRONT;
					end
					PHASE_FRONT: begin
						front_dist = value;
						aim = AIM_RIGHT;
						scan_state = PHASE_RIGHT;
					end
					default: begin
						right_dist = value;
						aim = AIM_FRONT;
						scan_state = PHASE_DONE;
					end
				endcase
				settle_cnt = '0;
			end
		end
		r.servo_position = aim;
		r.scan_phase = scan_state;
		r.scanning = scan_busy();
		r.scan_complete = scan_state == PHASE_DONE;
		r.sample_taken = took;
		r.left_distance = left_dist;
		r.front_distance = front_dist;
		r.right_distance = right_dist;
		if (scan_state != PHASE_DONE)
			r.best_direction = DIR_NONE;
		else if (front_dist >= left_dist && front_dist >= right_dist)
			r.best_direction = DIR_FRONT;
		else if (left_dist >= right_dist)
			r.best_direction = DIR_LEFT;
		else
			r.best_direction = DIR_RIGHT;
		return r;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		if (fail_count < 40)
			$display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
				results_checked, what, got, want);
		fail_count++;
	endtask

	task automatic compare_result(trss_out_t got, trss_out_t want);
		if (got.servo_position !== want.servo_position)
			report_mismatch("servo_position", got.servo_position, want.servo_position);
		if (got.scan_phase !== want.scan_phase)
			report_mismatch("scan_phase", got.scan_phase, want.scan_phase);
		if (got.scanning !== want.scanning)
			report_mismatch("scanning", got.scanning, want.scanning);
		if (got.scan_complete !== want.scan_complete)
			report_mismatch("scan_complete", got.scan_complete, want.scan_complete);
		if (got.sample_taken !== want.sample_taken)
			report_mismatch("sample_taken", got.sample_taken, want.sample_taken);
		if (got.left_distance !== want.left_distance)
			report_mismatch("left_distance", got.left_distance, want.left_distance);
		if (got.front_distance !== want.front_distance)
			report_mismatch("front_distance", got.front_distance, want.front_distance);
		if (got.right_distance !== want.right_distance)
			report_mismatch("right_distance", got.right_distance, want.right_distance);
		if (got.best_direction !== want.best_direction)
			report_mismatch("best_direction", got.best_direction, want.best_direction);
	endtask

	always @(posedge clk or negedge arst_n) begin
		trss_out_t want;
		if (!arst_n) begin
			settle_limit = SETTLE_TICKS_RST;
			fail_distance = MAX_DISTANCE_RST;
			scan_state = PHASE_IDLE;
			settle_cnt = '0;
			aim = AIM_FRONT;
			left_dist = '0;
			front_dist = '0;
			right_dist = '0;
			expected_results.delete();
			fail_count = 0;
			pending = 0;
			results_checked = 0;
			readings_stored = 0;
			scans_completed = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SETTLE_TICKS: settle_limit = cfg_data;
					CFG_MAX_DISTANCE: fail_distance = cfg_data;
				endcase
			end
			// input side first so a result can never outrun its own expectation
			if (in_valid && in_ready)
				expected_results.push_back(advance_scan(in_data));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing expected", 1, 0);
				end else begin
					want = expected_results.pop_front();
					compare_result(out_data, want);
					if (want.sample_taken)
						readings_stored++;
					if (want.sample_taken && want.scan_complete)
						scans_completed++;
				end
				results_checked++;
			end
			pending = expected_results.size();
		end
	end

endmodule

/* dv/tb_three_way_range_scan_sequencer.sv */
// Testbench top for the range scan sequencer: stimulus, handshake idling and verdict.
module tb_three_way_range_scan_sequencer;
	import trss_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int RANDOM_SETTINGS = 5;
	localparam int ITEMS_PER_SETTING = 180;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	trss_in_t in_data;
	logic out_valid;
	logic out_ready;
	trss_out_t out_data;
	logic cfg_we;
	cfg_index_t cfg_index;
	logic [15:0] cfg_data;

	int fail_count;
	int pending;
	int results_checked;
	int readings_stored;
	int scans_completed;

	logic idle_on;
	int items_sent;
	int directed_items;
	int quiet_cycles;

	three_way_range_scan_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	scan_result_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending),
		.results_checked(results_checked),
		.readings_stored(readings_stored),
		.scans_completed(scans_completed)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog: cycles without any transfer on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("timeout: no transfer for %0d cycles, %0d results outstanding",
				STALL_LIMIT, pending);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// receiver: random stall bursts while idling is on
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 4)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_item(op_t op, logic [15:0] reading, logic failed);
		trss_in_t item;
		int gap;
		item.req_type = op;
		item.distance_reading = reading;
		item.reading_failed = failed;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// lower valid and let every outstanding result drain
	task automatic drain_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_reading();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom_range(0, 3));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic send_tick();
		send_item(OP_TICK, pick_reading(), $urandom_range(0, 3) == 0);
	endtask

	initial begin
		logic [15:0] settle_set [RANDOM_SETTINGS];
		logic [15:0] max_set [RANDOM_SETTINGS];
		int phase_items;
		int ticks;

		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_SETTLE_TICKS;
		cfg_data = '0;
		arst_n = 1'b0;
		idle_on = 1'b1;
		items_sent = 0;
		quiet_cycles = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: idle tick, start with junk reading, one tick that cannot sample
		send_item(OP_TICK, 16'hFFFF, 1'b1);
		send_item(OP_START, 16'hA5A5, 1'b1);
		send_item(OP_TICK, 16'h1234, 1'b0);
		drain_block();
		write_reg(CFG_SETTLE_TICKS, 16'd0);

		// zero settle time: every tick during a scan samples; failures take the reset max distance
		send_item(OP_START, 16'h0000, 1'b0);
		send_item(OP_TICK, 16'hFFFF, 1'b0);
		send_item(OP_START, 16'h5555, 1'b1);
		send_item(OP_TICK, 16'h0000, 1'b1);
		send_item(OP_TICK, 16'h0000, 1'b0);
		send_item(OP_TICK, 16'h7777, 1'b0);
		send_item(OP_START, 16'hFFFF, 1'b1);
		// all equal: front wins
		send_item(OP_TICK, 16'd100, 1'b0);
		send_item(OP_TICK, 16'd100, 1'b0);
		send_item(OP_TICK, 16'd100, 1'b0);
		// right largest
		send_item(OP_START, 16'h0000, 1'b0);
		send_item(OP_TICK, 16'd5, 1'b0);
		send_item(OP_TICK, 16'd7, 1'b0);
		send_item(OP_TICK, 16'd9, 1'b0);
		// left ties right, both above front: left wins
		send_item(OP_START, 16'h0000, 1'b0);
		send_item(OP_TICK, 16'd9, 1'b0);
		send_item(OP_TICK, 16'd7, 1'b0);
		send_item(OP_TICK, 16'd9, 1'b0);
		directed_items = items_sent;
		drain_block();

		// longest settle time, then a lower limit while the counter is already past it
		idle_on = 1'b0;
		write_reg(CFG_SETTLE_TICKS, 16'hFFFF);
		send_item(OP_START, 16'h0000, 1'b0);
		repeat (20) send_tick();
		drain_block();
		write_reg(CFG_SETTLE_TICKS, 16'd3);
		repeat (5) send_tick();
		drain_block();

		settle_set = '{16'd1, 16'd0, 16'd2, 16'd5, 16'd3};
		max_set = '{16'h0000, 16'hFFFF, 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
		for (int s = 0; s < RANDOM_SETTINGS; s++) begin
			write_reg(CFG_SETTLE_TICKS, settle_set[s]);
			write_reg(CFG_MAX_DISTANCE, max_set[s]);
			phase_items = 0;
			while (phase_items < ITEMS_PER_SETTING) begin
				idle_on = (s != RANDOM_SETTINGS - 1) && ($urandom_range(0, 3) != 0);
				send_item(OP_START, pick_reading(), 1'($urandom_range(0, 1)));
				ticks = 3 * (settle_set[s] + 1) + $urandom_range(0, 2);
				phase_items += ticks + 1;
				for (int t = 0; t < ticks; t++) begin
					// stray start inside a scan is ignored
					if ($urandom_range(0, 15) == 0) begin
						send_item(OP_START, pick_reading(), 1'($urandom_range(0, 1)));
						phase_items++;
					end
					send_tick();
				end
			end
			drain_block();
		end

		repeat (10) @(negedge clk);
		$display("Covered %0d input transfers (%0d directed) over %0d settle settings",
			items_sent, directed_items, RANDOM_SETTINGS + 4);
		$display("Checked %0d results: %0d readings stored, %0d full scans",
			results_checked, readings_stored, scans_completed);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
